@@ rtl/ofs_pkg.sv @@
// Package for the orientation field similarity block.
// Holds widths, constants and the controller/datapath interface types.
// No dependencies.
package ofs_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int ANGLE_W    = 12;
	localparam int WGT_W      = 9;
	localparam int MAX_PAIRS  = 4096;
	localparam int CNT_W      = $clog2(MAX_PAIRS + 1);
	localparam int WSUM_W     = 10;
	localparam int TERM_W     = ANGLE_BITS + 2;
	localparam int PROD_W     = WSUM_W + 1 + TERM_W;
	localparam int WT_W       = 22;
	localparam int SUM_W      = 35;
	localparam int Q_BITS     = 13;
	localparam int STEP_W     = $clog2(Q_BITS);
	localparam int SCORE_W    = 14;

	localparam logic [WGT_W-1:0]   Q8_ONE        = WGT_W'(256);
	localparam logic [Q_BITS-1:0]  SCORE_ONE     = Q_BITS'(4096);
	localparam logic [SCORE_W-1:0] SCORE_NEG_ONE = SCORE_W'(-4096);

	typedef enum logic [1:0] {
		ST_ACC,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} ofs_state_t;

	typedef struct packed {
		logic acc_en;
		logic load;
		logic step;
		logic finish;
	} ofs_cmd_t;

	typedef struct packed {
		logic few_pairs;
		logic out_full;
	} ofs_stat_t;

endpackage

@@ rtl/ofs_ctrl.sv @@
// Controller for the orientation field similarity block.
// Sequences accumulate, divider load, divide steps and result write.
// Depends on ofs_pkg.
module ofs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_pair,
	input  ofs_pkg::ofs_stat_t stat,
	output logic              in_stall,
	output ofs_pkg::ofs_cmd_t  cmd
);
	import ofs_pkg::*;

	ofs_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		in_stall   = 1'b1;
		cmd        = '0;
		unique case (state_q)
			ST_ACC: begin
				in_stall   = stat.out_full & last_pair;
				cmd.acc_en = in_valid & ~in_stall;
				if (cmd.acc_en && last_pair) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				step_d   = '0;
				state_d  = stat.few_pairs ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				step_d   = step_q + STEP_W'(1);
				if (step_q == STEP_W'(Q_BITS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_ACC;
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

endmodule

@@ rtl/ofs_datapath.sv @@
// Datapath for the orientation field similarity block: weighted sums,
// restoring divider for the rounded ratio, output register.
// Depends on ofs_pkg.
module ofs_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ofs_pkg::ofs_cmd_t           cmd,
	output ofs_pkg::ofs_stat_t          stat,
	input  logic                        cfg_we,
	input  logic [ofs_pkg::CNT_W-1:0]   cfg_data,
	input  logic [ofs_pkg::ANGLE_W-1:0] angle_a,
	input  logic [ofs_pkg::WGT_W-1:0]   weight_a,
	input  logic [ofs_pkg::ANGLE_W-1:0] angle_f,
	input  logic [ofs_pkg::WGT_W-1:0]   weight_f,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [ofs_pkg::SCORE_W-1:0] score,
	output logic                        too_small,
	output logic [ofs_pkg::CNT_W-1:0]   pairs_counted
);
	import ofs_pkg::*;

	logic [CNT_W-1:0]         min_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [WT_W-1:0]          wt_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [ANGLE_BITS-1:0]    aa, af, adiff;
	logic [WGT_W-1:0]         wa, wf;
	logic [WSUM_W-1:0]        wsum;
	logic signed [TERM_W-1:0] term;
	logic signed [PROD_W-1:0] prod;
	logic                     pair_ok;

	logic                     neg;
	logic [SUM_W-1:0]         mag;
	logic [SUM_W:0]           numer;

	logic [WT_W:0]            rem_q, dvs_q;
	logic [Q_BITS-1:0]        quo_q, quo_c;
	logic [WT_W+1:0]          trial, trial_sub;
	logic                     ge;
	logic                     neg_q, small_q;
	logic [CNT_W-1:0]         hold_cnt_q;

	logic                     out_valid_q, small_out_q;
	logic [SCORE_W-1:0]       score_q, score_mag;
	logic [CNT_W-1:0]         pairs_q;

	always_comb begin
		aa      = angle_a[ANGLE_BITS-1:0];
		af      = angle_f[ANGLE_BITS-1:0];
		adiff   = (aa > af) ? aa - af : af - aa;
		wa      = (weight_a > Q8_ONE) ? Q8_ONE : weight_a;
		wf      = (weight_f > Q8_ONE) ? Q8_ONE : weight_f;
		wsum    = WSUM_W'(wa) + WSUM_W'(wf);
		term    = $signed(TERM_W'(1) << ANGLE_BITS) - $signed({1'b0, adiff, 1'b0});
		prod    = $signed({1'b0, wsum}) * term;
		pair_ok = (wa != '0) && (wf != '0) && (cnt_q < CNT_W'(MAX_PAIRS));
	end

	always_comb begin
		neg        = sum_q[SUM_W-1];
		mag        = neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		numer      = {mag, 1'b0} + (SUM_W+1)'(wt_q);
		stat.few_pairs = (cnt_q == '0) || (cnt_q < min_q) || (wt_q == '0);
		stat.out_full  = out_valid_q;
	end

	always_comb begin
		trial     = {rem_q, quo_q[Q_BITS-1]};
		trial_sub = trial - {1'b0, dvs_q};
		ge        = trial >= {1'b0, dvs_q};
		quo_c     = (quo_q > SCORE_ONE) ? SCORE_ONE : quo_q;
		score_mag = {1'b0, quo_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
		end else if (cfg_we) begin
			min_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			wt_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			sum_q <= '0;
			wt_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.acc_en && pair_ok) begin
			sum_q <= sum_q + SUM_W'(prod);
			wt_q  <= wt_q + WT_W'(wsum);
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q      <= (WT_W+1)'(numer[SUM_W:Q_BITS]);
			quo_q      <= numer[Q_BITS-1:0];
			dvs_q      <= {wt_q, 1'b0};
			neg_q      <= neg;
			small_q    <= stat.few_pairs;
			hold_cnt_q <= cnt_q;
		end else if (cmd.step) begin
			rem_q <= ge ? trial_sub[WT_W:0] : trial[WT_W:0];
			quo_q <= {quo_q[Q_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			score_q     <= small_q ? SCORE_NEG_ONE : (neg_q ? -score_mag : score_mag);
			small_out_q <= small_q;
			pairs_q     <= hold_cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign score         = $signed(score_q);
	assign too_small     = small_out_q;
	assign pairs_counted = pairs_q;

endmodule

@@ rtl/orientation_field_similarity.sv @@
// Weighted orientation field similarity: block pairs in, one score per window.
// Input channel in_valid/in_stall carries angle_a, weight_a, angle_f, weight_f
// and last_pair; a beat moves when valid is high and stall is low.
// Counted pairs (both weights nonzero) accumulate weight-times-agreement sums.
// Non-final pairs are taken one per cycle. After the final pair the input
// stalls while a 13-step restoring divider forms the rounded Q12 ratio;
// a window that is too small skips the divider (score -4096, too_small set).
// Output channel out_valid/out_stall carries score, too_small, pairs_counted
// from an output register; while it is held, non-final pairs are still
// taken and a final pair stalls until the result beat moves.
// cfg_we/cfg_data write min_overlap; write it only while idle.
// Reset clears sums, min_overlap and the output valid.
// Depends on ofs_pkg, ofs_ctrl, ofs_datapath.
module orientation_field_similarity (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ofs_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ofs_pkg::ANGLE_W-1:0] angle_a,
	input  logic [ofs_pkg::WGT_W-1:0]   weight_a,
	input  logic [ofs_pkg::ANGLE_W-1:0] angle_f,
	input  logic [ofs_pkg::WGT_W-1:0]   weight_f,
	input  logic                        last_pair,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [ofs_pkg::SCORE_W-1:0] score,
	output logic                        too_small,
	output logic [ofs_pkg::CNT_W-1:0]   pairs_counted
);
	import ofs_pkg::*;

	ofs_cmd_t  cmd;
	ofs_stat_t stat;

	ofs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pair (last_pair),
		.stat      (stat),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	ofs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.angle_a       (angle_a),
		.weight_a      (weight_a),
		.angle_f       (angle_f),
		.weight_f      (weight_f),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.score         (score),
		.too_small     (too_small),
		.pairs_counted (pairs_counted)
	);

endmodule
